/* hw/rtl/circle_point_generator_core_defines.svh */
// ----------------------------------------------------------------------------
// circle_point_generator_core_defines
// Assertion macros shared by the circle point generator RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_POINT_GENERATOR_CORE_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/cpg_pkg.sv */
// ----------------------------------------------------------------------------
// cpg_pkg
// Types and constants of the midpoint circle point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpg_pkg;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam int CoordW    = 8;
  localparam int DecisionW = 14;
  localparam int PointsPerStep = 8;
  localparam int PtIdxW    = $clog2(PointsPerStep);
  localparam logic [PtIdxW-1:0] LastPtIdx = PtIdxW'(PointsPerStep - 1);

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic              req_type;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] radius;
  } req_t;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              last;
    logic              circle_done;
  } point_t;

  // One step's worth of work: centre, offsets and whether it ends the circle.
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              done;
  } step_cmd_t;

  typedef struct packed {
    logic      valid;
    step_cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic      valid;
    step_cmd_t cmd;
  } cmd_head_t;

endpackage

`default_nettype wire

/* hw/rtl/cpg_front.sv */
// ----------------------------------------------------------------------------
// cpg_front
// Accepts requests, keeps the circle state and queues one command per step of a running circle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cpg_pkg::req_t req,
  input  wire logic          q_full,
  output cpg_pkg::cmd_push_t push
);
  import cpg_pkg::*;

  logic [CoordW-1:0]           centre_col;
  logic [CoordW-1:0]           centre_row;
  logic [CoordW-1:0]           offset_major;
  logic [CoordW-1:0]           offset_minor;
  logic signed [DecisionW-1:0] decision;
  logic                        active;

  logic                        accept;
  logic signed [CoordW:0]      nx;
  logic signed [CoordW+1:0]    ny;
  logic signed [DecisionW-1:0] f_mid;
  logic signed [DecisionW-1:0] decision_next;
  logic                        done;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;

  // Midpoint decision update
  always_comb begin
    nx    = $signed({1'b0, offset_major});
    f_mid = decision;
    if (!decision[DecisionW-1]) begin
      nx    = nx - 9'sd1;
      f_mid = decision - (DecisionW'(nx) <<< 2);
    end
    ny            = $signed({2'b00, offset_minor}) + 10'sd1;
    decision_next = f_mid + (DecisionW'(ny) <<< 2) + 14'sd2;
    done          = $signed({nx[CoordW], nx}) < ny;
  end

  assign push.valid    = accept && (req.req_type == REQ_STEP) && active;
  assign push.cmd.cx   = centre_col;
  assign push.cmd.cy   = centre_row;
  assign push.cmd.x    = offset_major;
  assign push.cmd.y    = offset_minor;
  assign push.cmd.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col   <= '0;
      centre_row   <= '0;
      offset_major <= '0;
      offset_minor <= '0;
      decision     <= '0;
      active       <= 1'b0;
    end else if (accept) begin
      if (req.req_type == REQ_START) begin
        centre_col   <= req.center_x;
        centre_row   <= req.center_y;
        offset_major <= req.radius;
        offset_minor <= '0;
        decision     <= 14'sd3 - $signed({5'b0, req.radius, 1'b0});
        active       <= 1'b1;
      end else if (active) begin
        if (done) begin
          active <= 1'b0;
        end else begin
          offset_major <= nx[CoordW-1:0];
          offset_minor <= ny[CoordW-1:0];
          decision     <= decision_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cpg_queue.sv */
// ----------------------------------------------------------------------------
// cpg_queue
// Short FIFO of step commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cpg_pkg::cmd_push_t push,
  input  wire logic               pop,
  output logic                    full,
  output cpg_pkg::cmd_head_t      head
);
  import cpg_pkg::*;

  step_cmd_t        mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == QCntW'(QueueDepth));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cpg_back.sv */
// ----------------------------------------------------------------------------
// cpg_back
// Walks the eight symmetric points of the command at the queue head.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cpg_pkg::cmd_head_t head,
  output logic                    pop,
  output logic                    point_valid,
  input  wire logic               point_ready,
  output cpg_pkg::point_t         point
);
  import cpg_pkg::*;

  logic [PtIdxW-1:0] idx;
  logic [CoordW-1:0] a;
  logic [CoordW-1:0] b;
  logic              fire;

  assign point_valid = head.valid;
  assign fire        = point_valid && point_ready;
  assign pop         = fire && (idx == LastPtIdx);

  // idx[2] swaps the octant pair, idx[0] negates the column, idx[1] the row
  always_comb begin
    a = idx[2] ? head.cmd.y : head.cmd.x;
    b = idx[2] ? head.cmd.x : head.cmd.y;
    point.point_x     = idx[0] ? head.cmd.cx - a : head.cmd.cx + a;
    point.point_y     = idx[1] ? head.cmd.cy - b : head.cmd.cy + b;
    point.last        = (idx == LastPtIdx);
    point.circle_done = (idx == LastPtIdx) && head.cmd.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/circle_point_generator_core.sv */
// ----------------------------------------------------------------------------
// circle_point_generator_core
// Midpoint circle rasterizer: start loads a circle, each step while it runs emits 8 points.
// ----------------------------------------------------------------------------
//  channel   signals                          payload
//  request   req_valid / req_ready            req   (cpg_pkg::req_t)
//  point     point_valid / point_ready        point (cpg_pkg::point_t)
//
//  A running circle's step request yields 8 points on the point channel, one
//  point per cycle while point_ready is high, walked by the back end's point
//  counter. Start requests and idle steps emit nothing. The front end takes a
//  new request every cycle while the two-entry command queue has room.
//  Reset (rst, synchronous) leaves the block idle with the queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_point_generator_core_defines.svh"

module circle_point_generator_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cpg_pkg::req_t req,
  output logic               point_valid,
  input  wire logic          point_ready,
  output cpg_pkg::point_t    point
);
  import cpg_pkg::*;

  cmd_push_t push;
  cmd_head_t head;
  logic      q_full;
  logic      pop;

  cpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push)
  );

  cpg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  cpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point)
  );

  `CPG_ASSERT_NOW(a_done_on_last, point_valid && point.circle_done, point.last, "done without last")
  `CPG_ASSERT_NOW(a_pop_nonempty, pop, head.valid, "pop from empty queue")
  `CPG_ASSERT_NEXT(a_push_kept, push.valid && !pop, head.valid, "pushed command lost")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circle_point_generator_core. A queue of start and
// step requests feeds a valid/ready driver. An in-bench midpoint-circle
// predictor turns each accepted step of a running circle into eight expected
// points. A monitor compares every point that arrives, field by field, with
// the oldest expected point. Both sides pause at random, and once the point
// side holds off long enough for the block to fill up and stall its requests.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpg_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int IDLE_PCT      = 11;
  localparam int RANDOM_REQS   = 420;
  localparam int HOLD_AT_POINT = 600;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 40;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   req_valid = 1'b0;
  logic   req_ready;
  req_t   req = '0;
  logic   point_valid;
  logic   point_ready = 1'b0;
  point_t point;

  req_t   pending_reqs[$];
  point_t expected_points[$];

  // Predictor state: the circle being drawn
  logic [CoordW-1:0] circ_col = '0;
  logic [CoordW-1:0] circ_row = '0;
  logic [CoordW-1:0] circ_major = '0;
  logic [CoordW-1:0] circ_minor = '0;
  int                circ_decision = 0;
  bit                circ_running = 1'b0;

  int errors = 0;
  int accepted_reqs = 0;
  int points_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  circle_point_generator_core uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic point_t make_point(logic [CoordW-1:0] px, logic [CoordW-1:0] py,
                                        logic lst, logic dn);
    point_t p;
    p.point_x     = px;
    p.point_y     = py;
    p.last        = lst;
    p.circle_done = dn;
    return p;
  endfunction

  // Start loads a circle; a step while running emits its eight points
  task automatic advance_circle(req_t r);
    int  nx;
    int  ny;
    int  f;
    bit  fin;
    if (r.req_type == REQ_START) begin
      circ_col      = r.center_x;
      circ_row      = r.center_y;
      circ_major    = r.radius;
      circ_minor    = '0;
      circ_decision = 3 - 2 * int'(r.radius);
      circ_running  = 1'b1;
    end else if (circ_running) begin
      nx = int'(circ_major);
      ny = int'(circ_minor);
      f  = circ_decision;
      if (f >= 0) begin
        nx = nx - 1;
        f  = f - 4 * nx;
      end
      ny  = ny + 1;
      f   = f + 4 * ny + 2;
      fin = (nx < ny);
      expected_points.push_back(make_point(circ_col + circ_major, circ_row + circ_minor,
                                           1'b0, 1'b0));
      expected_points.push_back(make_point(circ_col - circ_major, circ_row + circ_minor,
                                           1'b0, 1'b0));
      expected_points.push_back(make_point(circ_col + circ_major, circ_row - circ_minor,
                                           1'b0, 1'b0));
      expected_points.push_back(make_point(circ_col - circ_major, circ_row - circ_minor,
                                           1'b0, 1'b0));
      expected_points.push_back(make_point(circ_col + circ_minor, circ_row + circ_major,
                                           1'b0, 1'b0));
      expected_points.push_back(make_point(circ_col - circ_minor, circ_row + circ_major,
                                           1'b0, 1'b0));
      expected_points.push_back(make_point(circ_col + circ_minor, circ_row - circ_major,
                                           1'b0, 1'b0));
      expected_points.push_back(make_point(circ_col - circ_minor, circ_row - circ_major,
                                           1'b1, fin));
      if (fin) begin
        circ_running = 1'b0;
      end else begin
        circ_major    = nx[CoordW-1:0];
        circ_minor    = ny[CoordW-1:0];
        circ_decision = f;
      end
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    bit pause;
    if (!rst) begin
      if (req_valid && req_ready) begin
        advance_circle(req);
        accepted_reqs = accepted_reqs + 1;
      end
      if (!(req_valid && !req_ready)) begin
        pause = ($urandom_range(0, 99) < IDLE_PCT) &&
                !(accepted_reqs >= 180 && accepted_reqs < 280);
        if (pending_reqs.size() != 0 && !pause) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string name, int exp_val, int act_val);
    if (errors < MAX_REPORTS)
      $display("%0t: point %0d field %s expected %0d actual %0d",
               $time, points_seen, name, exp_val, act_val);
    errors = errors + 1;
  endtask

  // Point monitor
  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst) begin
      if (point_valid && point_ready) begin
        if (expected_points.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected point expected none actual x=%0d y=%0d last=%0d done=%0d",
                     $time, point.point_x, point.point_y, point.last, point.circle_done);
          errors = errors + 1;
        end else begin
          exp_pt = expected_points.pop_front();
          if (point.point_x !== exp_pt.point_x)
            report_field("point_x", int'(exp_pt.point_x), int'(point.point_x));
          if (point.point_y !== exp_pt.point_y)
            report_field("point_y", int'(exp_pt.point_y), int'(point.point_y));
          if (point.last !== exp_pt.last)
            report_field("last", int'(exp_pt.last), int'(point.last));
          if (point.circle_done !== exp_pt.circle_done)
            report_field("circle_done", int'(exp_pt.circle_done), int'(point.circle_done));
        end
        points_seen = points_seen + 1;
      end
      // Hold off once for a long stretch so the request side backs up
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        point_ready <= 1'b0;
      end else if (!hold_done && points_seen >= HOLD_AT_POINT) begin
        hold_done   = 1'b1;
        hold_left   = HOLD_CYCLES;
        point_ready <= 1'b0;
      end else begin
        point_ready <= !(($urandom_range(0, 99) < IDLE_PCT) &&
                         !(points_seen >= 900 && points_seen < 1400));
      end
    end
  end

  task automatic add_req(logic kind, logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
                         logic [CoordW-1:0] rad);
    req_t r;
    r.req_type = kind;
    r.center_x = cx;
    r.center_y = cy;
    r.radius   = rad;
    pending_reqs.push_back(r);
  endtask

  initial begin
    int pick;
    int sel;
    int rad;
    int full;
    int steps;

    // Directed: idle step, zero radius, extremes, drop of a running circle
    add_req(REQ_STEP, 8'hFF, 8'hFF, 8'hFF);
    add_req(REQ_START, 8'h00, 8'h00, 8'h00);
    add_req(REQ_STEP, 8'h00, 8'h00, 8'h00);
    add_req(REQ_STEP, 8'hFF, 8'h00, 8'hFF);
    add_req(REQ_START, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) add_req(REQ_STEP, 8'h00, 8'hFF, 8'h00);
    add_req(REQ_START, 8'h00, 8'hFF, 8'h01);
    repeat (3) add_req(REQ_STEP, 8'hAA, 8'h55, 8'hFF);
    add_req(REQ_START, 8'hFF, 8'h00, 8'h03);
    repeat (4) add_req(REQ_STEP, 8'h55, 8'hAA, 8'h00);
    add_req(REQ_START, 8'h80, 8'h80, 8'h80);
    add_req(REQ_STEP, 8'h00, 8'h00, 8'h00);
    add_req(REQ_STEP, 8'hFF, 8'hFF, 8'hFF);
    add_req(REQ_START, 8'h02, 8'hFE, 8'h05);
    repeat (5) add_req(REQ_STEP, 8'h12, 8'h34, 8'h56);

    // Random: mostly whole or cut-short circles, some noise
    while (pending_reqs.size() < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        sel = $urandom_range(0, 99);
        if (sel < 4)
          rad = $urandom_range(0, 255);
        else if (sel < 20)
          rad = $urandom_range(0, 40);
        else
          rad = $urandom_range(0, 12);
        add_req(REQ_START, CoordW'($urandom), CoordW'($urandom), CoordW'(rad));
        full = rad * 3 / 4 + 2;
        if ($urandom_range(0, 99) < 20)
          steps = $urandom_range(0, full);
        else
          steps = full + $urandom_range(0, 2);
        repeat (steps)
          add_req(REQ_STEP, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
      end else begin
        add_req(1'($urandom_range(0, 1)), CoordW'($urandom), CoordW'($urandom),
                CoordW'($urandom));
      end
    end

    @(posedge clk);
    while (rst) @(posedge clk);
    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
